### sv/stit_pkg.sv
`default_nettype none

package stit_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 8;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Entry layout in the slot memory: key in the low bits, tag above it.
    localparam int KEY_W   = 8;
    localparam int TAG_W   = 24;
    localparam int ENTRY_W = KEY_W + TAG_W;
    localparam int RIDX_W  = 3;

    // Stream widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Request kinds carried on s_tuser.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Sequencer states.
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] ST_SCAN_RD   = 4'd1;
    localparam logic [ST_W-1:0] ST_SCAN_CMP  = 4'd2;
    localparam logic [ST_W-1:0] ST_DECIDE    = 4'd3;
    localparam logic [ST_W-1:0] ST_SHIFT_RD  = 4'd4;
    localparam logic [ST_W-1:0] ST_SHIFT_WR  = 4'd5;
    localparam logic [ST_W-1:0] ST_PLACE     = 4'd6;
    localparam logic [ST_W-1:0] ST_READ_WAIT = 4'd7;
    localparam logic [ST_W-1:0] ST_FINISH    = 4'd8;

endpackage

`default_nettype wire

### sv/stit_ram.sv
`default_nettype none

module stit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/sorted_top_n_insert_table_core.sv
`default_nettype none

// Sorted top-N table: up to TABLE_DEPTH entries kept in ascending key order.
// Input channel (s_): s_tuser selects the request, 0 insert and 1 read;
// s_tdata carries the key, the tag and the read index. An insert lands after
// every stored entry with an equal or smaller key, pushes later entries down
// one slot and drops the last one when the table is full; an entry that ranks
// past a full table is not stored. A read returns the entry at the index.
// Result channel (m_): exactly one result per request, held in an output
// register until m_tready takes it.
// Structure: one shared key comparator and a slot memory with one write port
// and one registered read port work under a small sequencer. A read latches
// the slot in READ_WAIT and reports in FINISH, or goes to FINISH at once when
// the index is past the entry count. An insert runs SCAN_RD/SCAN_CMP per
// slot compared, DECIDE, SHIFT_RD/SHIFT_WR per slot shifted, PLACE and FINISH.
// s_tready is high only while the sequencer is idle. A stalled result holds
// the sequencer in its final step until the output register frees up.
// After aresetn the table is empty; slots are not cleared, since only slots
// below the entry count are ever read.
module sorted_top_n_insert_table_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [7:0] key_time, [31:8] entry_tag, [34:32] read_index, [39:35] zero
    input  wire logic [stit_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] req_type
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] placed, [3:1] place_index, [7:4] entry_count, [8] read_valid,
    // [16:9] read_key, [40:17] read_tag, [47:41] zero
    output logic      [stit_pkg::M_TDATA_W-1:0]   m_tdata
);

    import stit_pkg::*;

    logic [ST_W-1:0]      state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic                 placed_reg, placed_next;
    logic                 rvalid_reg, rvalid_next;
    logic [KEY_W-1:0]     rkey_reg, rkey_next;
    logic [TAG_W-1:0]     rtag_reg, rtag_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [ENTRY_W-1:0]   ram_wr_data;
    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [ENTRY_W-1:0]   ram_rd_data;

    logic [7:0]           in_ridx_wide;
    logic [7:0]           count_wide;
    logic [7:0]           pos_wide;
    logic [CNT_W-1:0]     idx_inc;
    logic [CNT_W-1:0]     idx_dec;
    logic [CNT_W-1:0]     last_slot;

    stit_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ridx_wide = 8'(s_tdata[34:32]);
    assign count_wide   = 8'(count_reg);
    assign pos_wide     = 8'(pos_reg);
    assign idx_inc      = CNT_W'(idx_reg + 1'b1);
    assign idx_dec      = CNT_W'(idx_reg - 1'b1);
    // A full table shifts from its last slot; otherwise the first free slot.
    assign last_slot    = (count_reg < CNT_W'(TABLE_DEPTH)) ? count_reg
                                                            : CNT_W'(TABLE_DEPTH - 1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        tag_next      = tag_reg;
        placed_next   = placed_reg;
        rvalid_next   = rvalid_reg;
        rkey_next     = rkey_reg;
        rtag_next     = rtag_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = idx_reg[ADDR_W-1:0];
        ram_wr_data   = ram_rd_data;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_next    = s_tdata[7:0];
                    tag_next    = s_tdata[31:8];
                    placed_next = 1'b0;
                    pos_next    = '0;
                    idx_next    = '0;
                    rvalid_next = 1'b0;
                    rkey_next   = '0;
                    rtag_next   = '0;
                    if (s_tuser == REQ_READ) begin
                        if (in_ridx_wide < count_wide) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = in_ridx_wide[ADDR_W-1:0];
                            state_next  = ST_READ_WAIT;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end else if (count_reg == '0) begin
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_reg[ADDR_W-1:0];
                state_next  = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                // Stop at the first stored key strictly larger than the new one.
                if (key_reg < ram_rd_data[KEY_W-1:0]) begin
                    pos_next   = idx_reg;
                    state_next = ST_DECIDE;
                end else if (idx_inc == count_reg) begin
                    pos_next   = count_reg;
                    state_next = ST_DECIDE;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DECIDE: begin
                if (pos_reg == CNT_W'(TABLE_DEPTH)) begin
                    // Ranks past a full table: dropped, table unchanged.
                    pos_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = last_slot;
                    state_next = (last_slot > pos_reg) ? ST_SHIFT_RD : ST_PLACE;
                end
            end
            ST_SHIFT_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_dec[ADDR_W-1:0];
                state_next  = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg[ADDR_W-1:0];
                ram_wr_data = ram_rd_data;
                idx_next    = idx_dec;
                state_next  = (idx_dec > pos_reg) ? ST_SHIFT_RD : ST_PLACE;
            end
            ST_PLACE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg[ADDR_W-1:0];
                ram_wr_data = {tag_reg, key_reg};
                placed_next = 1'b1;
                if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                    count_next = CNT_W'(count_reg + 1'b1);
                end
                state_next = ST_FINISH;
            end
            ST_READ_WAIT: begin
                rvalid_next = 1'b1;
                rkey_next   = ram_rd_data[KEY_W-1:0];
                rtag_next   = ram_rd_data[ENTRY_W-1:KEY_W];
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {7'd0, rtag_reg, rkey_reg, rvalid_reg,
                                     count_wide[3:0], pos_wide[2:0], placed_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        tag_reg     <= tag_next;
        placed_reg  <= placed_next;
        rvalid_reg  <= rvalid_next;
        rkey_reg    <= rkey_next;
        rtag_reg    <= rtag_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_only_on_place: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_PLACE) |=> $stable(count_reg))
        else $error("entry count changed outside the place step");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_RD) |-> (idx_reg < count_reg))
        else $error("scan index beyond valid entries");

    a_shift_above_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT_WR) |-> (idx_reg > pos_reg))
        else $error("shift write at or above the insertion slot");

    a_placed_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[0]) |-> (m_tdata_reg[7:4] != 4'd0 || CNT_W > 4))
        else $error("placed entry reported with an empty table");
`endif

endmodule

`default_nettype wire
